FILE: rtl/core/note_start_jitter_splitmix_assert.svh
// Assertion macros for the port-level checker.
`ifndef NOTE_START_JITTER_SPLITMIX_ASSERT_SVH
`define NOTE_START_JITTER_SPLITMIX_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define NSJ_ASSERT_IMPL(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("nsj assertion failed");

// Next-cycle implication, disabled while reset is active.
`define NSJ_ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("nsj assertion failed");

`endif

FILE: rtl/core/nsj_pkg.sv
// ----------------------------------------------------------------------------
// nsj_pkg
// Shared widths, constants and controller/datapath types of the note-start
// jitter block.
// ----------------------------------------------------------------------------
`default_nettype none

package nsj_pkg;

	localparam int TICK_W     = 32;
	localparam int LIMIT_W    = 24;
	localparam int GEN_W      = 64;
	localparam int HALF_W     = GEN_W / 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;
	localparam int DIV_W      = LIMIT_W + 1;
	localparam int SUM_W      = TICK_W + 2;
	localparam int CNT_W      = 6;
	localparam int MUL_STEPS  = 3;
	localparam int DIV_STEPS  = GEN_W;

	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_SEED  = CFG_IDX_W'(1);

	localparam logic [GEN_W-1:0] GOLDEN_INC = 64'h9E37_79B9_7F4A_7C15;
	localparam logic [GEN_W-1:0] MIX_MUL_A  = 64'hBF58_476D_1CE4_E5B9;
	localparam logic [GEN_W-1:0] MIX_MUL_B  = 64'h94D0_49BB_1331_11EB;
	localparam int SHIFT_A = 30;
	localparam int SHIFT_B = 27;
	localparam int SHIFT_C = 31;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADV,
		ST_MULA,
		ST_MIXA,
		ST_MULB,
		ST_MIXB,
		ST_DIV,
		ST_FIN
	} ctl_state_t;

	// Partial product being accumulated: low*low, high*low, low*high.
	typedef enum logic [1:0] {
		MP_LL,
		MP_HL,
		MP_LH
	} mul_phase_t;

	typedef struct packed {
		logic       load_in;
		logic       advance;
		logic       mul_en;
		mul_phase_t mul_phase;
		logic       mul_sel_b;
		logic       mix_a;
		logic       mix_b;
		logic       div_step;
		logic       load_out;
	} nsj_cmd_t;

	typedef struct packed {
		logic jit_req;
	} nsj_status_t;

endpackage

`default_nettype wire

FILE: rtl/core/nsj_ctrl.sv
// ----------------------------------------------------------------------------
// nsj_ctrl
// Sequencer: accepts one transaction, walks a jittered note through generator
// advance, two multiply/mix rounds, the remainder loop; each ends in the clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module nsj_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  wire logic                out_stall,
	input  wire nsj_pkg::nsj_status_t status,
	output nsj_pkg::nsj_cmd_t        cmd
);

	nsj_pkg::ctl_state_t state_q, state_d;
	logic [nsj_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nsj_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		case (state_q)
			nsj_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d = status.jit_req ? nsj_pkg::ST_ADV : nsj_pkg::ST_FIN;
				end
			end
			nsj_pkg::ST_ADV: begin
				cmd.advance = 1'b1;
				cnt_d = '0;
				state_d = nsj_pkg::ST_MULA;
			end
			nsj_pkg::ST_MULA: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_phase = nsj_pkg::mul_phase_t'(cnt_q[1:0]);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == nsj_pkg::CNT_W'(nsj_pkg::MUL_STEPS - 1)) begin
					state_d = nsj_pkg::ST_MIXA;
				end
			end
			nsj_pkg::ST_MIXA: begin
				cmd.mix_a = 1'b1;
				cnt_d = '0;
				state_d = nsj_pkg::ST_MULB;
			end
			nsj_pkg::ST_MULB: begin
				cmd.mul_en    = 1'b1;
				cmd.mul_sel_b = 1'b1;
				cmd.mul_phase = nsj_pkg::mul_phase_t'(cnt_q[1:0]);
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == nsj_pkg::CNT_W'(nsj_pkg::MUL_STEPS - 1)) begin
					state_d = nsj_pkg::ST_MIXB;
				end
			end
			nsj_pkg::ST_MIXB: begin
				cmd.mix_b = 1'b1;
				cnt_d = '0;
				state_d = nsj_pkg::ST_DIV;
			end
			nsj_pkg::ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == nsj_pkg::CNT_W'(nsj_pkg::DIV_STEPS - 1)) begin
					state_d = nsj_pkg::ST_FIN;
				end
			end
			nsj_pkg::ST_FIN: begin
				// hold until the output register is free or being drained
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_d = nsj_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nsj_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_stall  = (state_q != nsj_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

endmodule

`default_nettype wire

FILE: rtl/core/nsj_datapath.sv
// ----------------------------------------------------------------------------
// nsj_datapath
// Configuration registers, splitmix64 state, shared 32x32 multiplier,
// bit-serial remainder and the displacement clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module nsj_datapath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [nsj_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [nsj_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  wire logic signed [nsj_pkg::TICK_W-1:0]   tick_in,
	input  wire logic                                is_note,
	input  wire logic                                restart,
	input  wire nsj_pkg::nsj_cmd_t                   cmd,
	output nsj_pkg::nsj_status_t                     status,
	output logic signed [nsj_pkg::TICK_W-1:0]        tick_out
);

	logic [nsj_pkg::LIMIT_W-1:0] limit_q;
	logic [nsj_pkg::GEN_W-1:0]   seed_q;
	logic [nsj_pkg::GEN_W-1:0]   gen_q;
	logic                        jit_q;
	logic [nsj_pkg::TICK_W-1:0]  tick_q;
	logic [nsj_pkg::GEN_W-1:0]   z_q;
	logic [nsj_pkg::GEN_W-1:0]   acc_q;
	logic [nsj_pkg::DIV_W-1:0]   rem_q;
	logic [nsj_pkg::TICK_W-1:0]  tick_out_q;

	logic [nsj_pkg::GEN_W-1:0]  gen_next;
	logic [nsj_pkg::GEN_W-1:0]  mul_const;
	logic [nsj_pkg::HALF_W-1:0] mul_x, mul_y;
	logic [nsj_pkg::GEN_W-1:0]  prod;

	logic [nsj_pkg::DIV_W-1:0]  span;
	logic [nsj_pkg::DIV_W:0]    div_t;
	logic [nsj_pkg::DIV_W-1:0]  rem_d;

	logic [nsj_pkg::DIV_W-1:0]  lim_ext;
	logic                       dpos;
	logic [nsj_pkg::DIV_W-1:0]  dmag;
	logic [nsj_pkg::SUM_W-1:0]  tick_ext, dmag_ext, sum;
	logic [nsj_pkg::SUM_W-1:0]  maxpos_ext;
	logic [nsj_pkg::TICK_W-1:0] clamped, result;

	assign status.jit_req = is_note && (limit_q != '0);

	// configuration and generator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			seed_q  <= '0;
			gen_q   <= '0;
			jit_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					nsj_pkg::CFG_LIMIT: limit_q <= cfg_data[nsj_pkg::LIMIT_W-1:0];
					nsj_pkg::CFG_SEED:  seed_q  <= cfg_data;
					default: begin
						// drop writes beyond the register list
					end
				endcase
			end
			if (cmd.load_in) begin
				jit_q <= status.jit_req;
				if (restart) begin
					gen_q <= seed_q;
				end
			end else if (cmd.advance) begin
				gen_q <= gen_next;
			end
		end
	end

	assign gen_next = gen_q + nsj_pkg::GOLDEN_INC;

	// one 32x32 partial product per cycle, low 64 bits kept
	assign mul_const = cmd.mul_sel_b ? nsj_pkg::MIX_MUL_B : nsj_pkg::MIX_MUL_A;
	assign mul_x = (cmd.mul_phase == nsj_pkg::MP_HL) ? z_q[nsj_pkg::GEN_W-1:nsj_pkg::HALF_W]
	                                                 : z_q[nsj_pkg::HALF_W-1:0];
	assign mul_y = (cmd.mul_phase == nsj_pkg::MP_LH)
	             ? mul_const[nsj_pkg::GEN_W-1:nsj_pkg::HALF_W]
	             : mul_const[nsj_pkg::HALF_W-1:0];
	assign prod = {{nsj_pkg::HALF_W{1'b0}}, mul_x} * {{nsj_pkg::HALF_W{1'b0}}, mul_y};

	// restoring remainder, one dividend bit per step
	assign span  = {limit_q, 1'b1};
	assign div_t = {rem_q, z_q[nsj_pkg::GEN_W-1]};
	always_comb begin
		if (div_t >= {1'b0, span}) begin
			rem_d = nsj_pkg::DIV_W'(div_t - {1'b0, span});
		end else begin
			rem_d = div_t[nsj_pkg::DIV_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			tick_q <= tick_in;
		end
		if (cmd.advance) begin
			z_q <= gen_next ^ (gen_next >> nsj_pkg::SHIFT_A);
		end else if (cmd.mix_a) begin
			z_q <= acc_q ^ (acc_q >> nsj_pkg::SHIFT_B);
		end else if (cmd.mix_b) begin
			z_q <= acc_q ^ (acc_q >> nsj_pkg::SHIFT_C);
		end else if (cmd.div_step) begin
			z_q <= {z_q[nsj_pkg::GEN_W-2:0], 1'b0};
		end
		if (cmd.mul_en) begin
			if (cmd.mul_phase == nsj_pkg::MP_LL) begin
				acc_q <= prod;
			end else begin
				acc_q[nsj_pkg::GEN_W-1:nsj_pkg::HALF_W] <=
					acc_q[nsj_pkg::GEN_W-1:nsj_pkg::HALF_W] + prod[nsj_pkg::HALF_W-1:0];
			end
		end
		if (cmd.mix_b) begin
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= rem_d;
		end
		if (cmd.load_out) begin
			tick_out_q <= result;
		end
	end

	// displacement = draw - limit, then clamp to [0, max positive tick]
	assign lim_ext  = {1'b0, limit_q};
	assign dpos     = (rem_q >= lim_ext);
	assign dmag     = dpos ? (rem_q - lim_ext) : (lim_ext - rem_q);
	assign tick_ext = {{2{tick_q[nsj_pkg::TICK_W-1]}}, tick_q};
	assign dmag_ext = {{(nsj_pkg::SUM_W - nsj_pkg::DIV_W){1'b0}}, dmag};
	assign sum      = dpos ? (tick_ext + dmag_ext) : (tick_ext - dmag_ext);
	assign maxpos_ext = {{3{1'b0}}, {(nsj_pkg::TICK_W - 1){1'b1}}};

	always_comb begin
		if (sum[nsj_pkg::SUM_W-1]) begin
			clamped = '0;
		end else if (sum > maxpos_ext) begin
			clamped = maxpos_ext[nsj_pkg::TICK_W-1:0];
		end else begin
			clamped = sum[nsj_pkg::TICK_W-1:0];
		end
	end

	assign result   = jit_q ? clamped : tick_q;
	assign tick_out = tick_out_q;

endmodule

`default_nettype wire

FILE: rtl/core/note_start_jitter_splitmix.sv
// ----------------------------------------------------------------------------
// note_start_jitter_splitmix
// Note-start humanizer: displaces note ticks by a splitmix64 draw.
// ----------------------------------------------------------------------------
// One event is handled at a time. A note with a nonzero jitter limit keeps the
// sequencer busy after acceptance: it advances the generator, runs two rounds
// through the single shared 32x32 multiplier, three partial products and a
// mix step each, then the bit-serial remainder by 2*limit+1 and the clamp.
// The result is offered in the cycle after the clamp, and the next event can
// then be accepted. Any other event (non-note, or limit zero) goes straight
// from acceptance to the clamp, which passes its tick through unchanged.
// A finished result sits in the output register while the next event is
// accepted; a stalled output register holds the sequencer in its final state.
// Restart reloads the generator from the seed before the event is processed,
// even when no draw follows. Write configuration only while the block is idle.
`default_nettype none

module note_start_jitter_splitmix (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [nsj_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [nsj_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic signed [nsj_pkg::TICK_W-1:0] tick_in,
	input  wire logic                              is_note,
	input  wire logic                              restart,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic signed [nsj_pkg::TICK_W-1:0]      tick_out
);

	nsj_pkg::nsj_cmd_t    cmd;
	nsj_pkg::nsj_status_t status;

	nsj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.cmd       (cmd)
	);

	nsj_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.tick_in   (tick_in),
		.is_note   (is_note),
		.restart   (restart),
		.cmd       (cmd),
		.status    (status),
		.tick_out  (tick_out)
	);

endmodule

`default_nettype wire

FILE: rtl/core/nsj_checker.sv
// ----------------------------------------------------------------------------
// nsj_checker
// Port-level checks on the note-start jitter block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "note_start_jitter_splitmix_assert.svh"

module nsj_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire logic [nsj_pkg::TICK_W-1:0] tick_out
);

	// a pending result stays offered while stalled
	`NSJ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid)
	`NSJ_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall, $stable(tick_out))
	// one transaction at a time: the block is busy right after an accept
	`NSJ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)
	// a new result only appears at the end of a busy period
	`NSJ_ASSERT_IMPL(a_result_from_busy, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind note_start_jitter_splitmix nsj_checker u_nsj_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.tick_out  (tick_out)
);

`default_nettype wire

FILE: bench/note_start_jitter_splitmix_tb.sv
// ----------------------------------------------------------------------------
// note_start_jitter_splitmix_tb
// Self-checking bench for the note-start jitter block. A clocked driver feeds
// events from a pending queue. A built-in splitmix64 predictor computes the
// displaced tick of each accepted event, and a monitor compares every output
// transaction with the oldest prediction. Phases vary the jitter limit, the
// seed and the amount of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module note_start_jitter_splitmix_tb;

	// Indexes past the register list; writes to them must be ignored.
	localparam logic [nsj_pkg::CFG_IDX_W-1:0] CFG_NO_REG_2 = nsj_pkg::CFG_IDX_W'(2);
	localparam logic [nsj_pkg::CFG_IDX_W-1:0] CFG_NO_REG_3 = nsj_pkg::CFG_IDX_W'(3);

	localparam longint TICK_MAX      = (longint'(1) << (nsj_pkg::TICK_W - 1)) - 1;
	localparam int     CYCLE_LIMIT   = 1000000;
	localparam int     SETTLE_CYCLES = 90;
	localparam int     HOLD_CYCLES   = 3000;
	localparam int     PHASE_ITEMS   = 290;

	typedef struct packed {
		logic [nsj_pkg::TICK_W-1:0] tick;
		logic                       note;
		logic                       rst;
	} note_evt_t;

	logic                              clk;
	logic                              arst_n = 1'b0;
	logic                              cfg_we = 1'b0;
	logic [nsj_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
	logic [nsj_pkg::CFG_DATA_W-1:0]    cfg_data = '0;
	logic                              in_valid = 1'b0;
	logic                              in_stall;
	logic signed [nsj_pkg::TICK_W-1:0] tick_in = '0;
	logic                              is_note = 1'b0;
	logic                              restart = 1'b0;
	logic                              out_valid;
	logic                              out_stall = 1'b0;
	logic signed [nsj_pkg::TICK_W-1:0] tick_out;

	// Predictor copy of the registers and the generator.
	logic [nsj_pkg::LIMIT_W-1:0] lim_reg = '0;
	logic [nsj_pkg::GEN_W-1:0]   seed_reg = '0;
	logic [nsj_pkg::GEN_W-1:0]   rng_state = '0;

	note_evt_t                  evt_queue[$];
	logic [nsj_pkg::TICK_W-1:0] tick_expect_q[$];
	note_evt_t                  cur_evt;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int err_cnt = 0;
	int cycle_cnt = 0;
	int hold_left = 0;
	bit hold_armed = 1'b0;
	bit hold_done = 1'b0;

	note_start_jitter_splitmix dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.tick_in  (tick_in),
		.is_note  (is_note),
		.restart  (restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.tick_out (tick_out)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Reseed on restart; for a jittered note advance the generator and clamp.
	function automatic logic [nsj_pkg::TICK_W-1:0] jitter_tick(
			logic [nsj_pkg::TICK_W-1:0] tick, logic note, logic rst);
		logic [nsj_pkg::GEN_W-1:0] mix;
		logic [nsj_pkg::GEN_W-1:0] span;
		logic [nsj_pkg::GEN_W-1:0] draw;
		longint                    moved;
		if (rst)
			rng_state = seed_reg;
		if (!note || lim_reg == '0)
			return tick;
		rng_state = rng_state + nsj_pkg::GOLDEN_INC;
		mix = rng_state;
		mix = (mix ^ (mix >> nsj_pkg::SHIFT_A)) * nsj_pkg::MIX_MUL_A;
		mix = (mix ^ (mix >> nsj_pkg::SHIFT_B)) * nsj_pkg::MIX_MUL_B;
		mix = mix ^ (mix >> nsj_pkg::SHIFT_C);
		span = nsj_pkg::GEN_W'(lim_reg) * 2 + 1;
		draw = mix % span;
		moved = longint'(signed'(tick)) + longint'(draw)
			- longint'(nsj_pkg::GEN_W'(lim_reg));
		if (moved < 0)
			return '0;
		if (moved > TICK_MAX)
			return nsj_pkg::TICK_W'(TICK_MAX);
		return moved[nsj_pkg::TICK_W-1:0];
	endfunction

	// Ticks near zero, near either end of the range, small ones or random words.
	function automatic logic [nsj_pkg::TICK_W-1:0] pick_tick(
			logic [nsj_pkg::LIMIT_W-1:0] lim);
		case ($urandom_range(4))
			0: return $urandom();
			1: return $urandom_range(32'(lim) * 2 + 8) - (32'(lim) + 4);
			2: return nsj_pkg::TICK_W'(TICK_MAX) - $urandom_range(32'(lim) + 4);
			3: return {1'b1, {(nsj_pkg::TICK_W-1){1'b0}}} + $urandom_range(32'(lim) + 4);
			default: return $urandom_range(100000);
		endcase
	endfunction

	task automatic queue_evt(logic [nsj_pkg::TICK_W-1:0] tick, logic note, logic rst);
		note_evt_t e;
		e.tick = tick;
		e.note = note;
		e.rst  = rst;
		evt_queue = {evt_queue, e};
	endtask

	task automatic set_reg(logic [nsj_pkg::CFG_IDX_W-1:0] idx,
			logic [nsj_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == nsj_pkg::CFG_LIMIT)
			lim_reg = data[nsj_pkg::LIMIT_W-1:0];
		else if (idx == nsj_pkg::CFG_SEED)
			seed_reg = data;
	endtask

	// Wait for every transaction to retire, then let the sequencer go quiet.
	// Sample between edges so the driver's updates of this edge are visible.
	task automatic settle();
		@(negedge clk);
		while (evt_queue.size() != 0 || in_valid || tick_expect_q.size() != 0 || in_stall)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the limit with junk above bit 23 so the masking is exercised too.
	task automatic set_limit(logic [nsj_pkg::LIMIT_W-1:0] lim);
		set_reg(nsj_pkg::CFG_LIMIT, {$urandom(), 8'($urandom()), lim});
	endtask

	// Driver: hold a stalled transaction, otherwise offer the next event.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				tick_expect_q = {tick_expect_q,
					jitter_tick(cur_evt.tick, cur_evt.note, cur_evt.rst)};
			if (!in_valid || !in_stall) begin
				if (evt_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_evt = evt_queue.pop_front();
					in_valid <= 1'b1;
					tick_in  <= cur_evt.tick;
					is_note  <= cur_evt.note;
					restart  <= cur_evt.rst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off to back the block up.
	always @(posedge clk) begin
		if (hold_armed && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor
	always @(posedge clk) begin
		logic [nsj_pkg::TICK_W-1:0] want;
		if (arst_n && out_valid && !out_stall) begin
			if (tick_expect_q.size() == 0) begin
				$display("%0t: unexpected tick_out transaction: expected none, got %0d",
					$time, tick_out);
				err_cnt++;
			end else begin
				want = tick_expect_q.pop_front();
				if (tick_out !== want) begin
					$display("%0t: tick_out mismatch: expected %0d, got %0d",
						$time, $signed(want), tick_out);
					err_cnt++;
				end
			end
		end
	end

	initial begin : watchdog
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : main_seq
		logic [nsj_pkg::TICK_W-1:0]  tmax;
		logic [nsj_pkg::TICK_W-1:0]  tmin;
		logic [nsj_pkg::LIMIT_W-1:0] lim;
		tmax = nsj_pkg::TICK_W'(TICK_MAX);
		tmin = {1'b1, {(nsj_pkg::TICK_W-1){1'b0}}};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Jitter off: a restart must still load the seed.
		set_reg(nsj_pkg::CFG_SEED, 64'h0123_4567_89AB_CDEF);
		set_reg(nsj_pkg::CFG_LIMIT, 64'hFFFF_FFFF_FF00_0000);
		set_reg(CFG_NO_REG_2, 64'h0000_0000_0000_0007);
		set_reg(CFG_NO_REG_3, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_evt(tmin, 1'b1, 1'b0);
		queue_evt(tmax, 1'b1, 1'b0);
		queue_evt('1, 1'b1, 1'b0);
		queue_evt('0, 1'b0, 1'b0);
		queue_evt(12345, 1'b1, 1'b1);
		queue_evt(-77, 1'b0, 1'b1);
		settle();

		// Widest limit: saturation at the top, clamping of negative ticks.
		set_reg(nsj_pkg::CFG_LIMIT, '1);
		queue_evt(tmax, 1'b1, 1'b0);
		queue_evt(tmax, 1'b1, 1'b0);
		queue_evt(tmax - 1, 1'b1, 1'b0);
		queue_evt(tmin, 1'b1, 1'b0);
		queue_evt('1, 1'b1, 1'b0);
		queue_evt(-5, 1'b1, 1'b0);
		queue_evt('0, 1'b1, 1'b0);
		queue_evt(1, 1'b1, 1'b0);
		queue_evt(tmax, 1'b0, 1'b0);
		queue_evt(tmin, 1'b0, 1'b1);
		queue_evt(100, 1'b1, 1'b1);
		queue_evt(tmax, 1'b1, 1'b0);
		settle();

		// Smallest nonzero limit.
		set_limit(1);
		set_reg(nsj_pkg::CFG_SEED, '1);
		queue_evt('0, 1'b1, 1'b1);
		queue_evt('0, 1'b1, 1'b0);
		queue_evt('1, 1'b1, 1'b0);
		queue_evt(tmax, 1'b1, 1'b0);
		queue_evt(tmin, 1'b1, 1'b0);
		queue_evt(2, 1'b1, 1'b0);
		settle();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin lim = $urandom_range(64, 1); send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin lim = 1; send_idle_pct = 88; recv_stall_pct = 0; end
				2: begin lim = '1; send_idle_pct = 0; recv_stall_pct = 88; end
				3: begin lim = $urandom(); send_idle_pct = 6; recv_stall_pct = 6; end
				4: begin lim = '0; send_idle_pct = 88; recv_stall_pct = 88; end
				default: begin lim = $urandom_range(1000, 1); send_idle_pct = 0; recv_stall_pct = 0; end
			endcase
			case (ph)
				1, 5: set_reg(nsj_pkg::CFG_SEED, '0);
				4: set_reg(nsj_pkg::CFG_SEED, '1);
				default: set_reg(nsj_pkg::CFG_SEED, {$urandom(), $urandom()});
			endcase
			set_limit(lim);
			for (int n = 0; n < PHASE_ITEMS; n++)
				queue_evt(pick_tick(lim), $urandom_range(99) < 70, $urandom_range(99) < 5);
			// Back the block up while the sender keeps offering.
			if (ph == 2)
				hold_armed = 1'b1;
			settle();
		end

		if (err_cnt == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: note_start_jitter_splitmix.f
+incdir+rtl/core
rtl/core/nsj_pkg.sv
rtl/core/nsj_ctrl.sv
rtl/core/nsj_datapath.sv
rtl/core/note_start_jitter_splitmix.sv
rtl/core/nsj_checker.sv
bench/note_start_jitter_splitmix_tb.sv
